### hw/rtl/ttrc_pkg.sv
package ttrc_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] term_type;

   localparam term_type TERM_MOD     = 16'hFFFF;
   localparam term_type TERM_ONE     = 16'd1;
   localparam byte_type FIRST_OFFSET = 8'd7;
   localparam byte_type ALPHA_MULT   = 8'd17;
   localparam byte_type BETA_MULT    = 8'd31;

   // multiple of the modulus above the largest negative difference
   localparam logic [25:0] MOD_BIAS = 26'(32'd65535 * 32'd257);

endpackage

### hw/rtl/three_term_recurrence_checksum_top.sv
// Three-term recurrence checksum. Bytes of a message arrive one per item on the
// req_ channel, req_last_byte marking the final byte; the checksum of the whole
// message comes out as one rsp_ item after that final byte, and the block then
// starts over on the next message. Throughput is one byte per clock: the byte is
// captured in an input register and the next term is formed in the following
// cycle by two small multipliers and a mod-65535 fold, so a checksum is presented
// on rsp_ from an output register once its last byte leaves the input register.
// Non-final bytes produce no item. A final byte waits in the input register while
// an earlier checksum is still held under rsp_stall, and req_stall is high for
// those cycles, so the bytes behind it wait as well.
module three_term_recurrence_checksum_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ttrc_pkg::byte_type req_data_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ttrc_pkg::term_type rsp_checksum
);

   logic               in_valid_ff, in_valid_in;
   ttrc_pkg::byte_type in_data_ff, in_data_in;
   logic               in_last_ff, in_last_in;

   logic               first_ff, first_in;
   ttrc_pkg::byte_type idx_ff, idx_in;
   ttrc_pkg::term_type cur_ff, cur_in;
   ttrc_pkg::term_type prev_ff, prev_in;

   logic               out_valid_ff, out_valid_in;
   ttrc_pkg::term_type out_sum_ff, out_sum_in;

   logic               out_free;
   logic               advance;
   logic               accept;
   ttrc_pkg::term_type term;
   ttrc_pkg::term_type cur_next;
   ttrc_pkg::term_type prev_next;
   ttrc_pkg::byte_type idx_next;

   ttrc_term u_term (
      .data_i (in_data_ff),
      .idx_i  (idx_ff),
      .cur_i  (cur_ff),
      .prev_i (prev_ff),
      .term_o (term)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid    = out_valid_ff;
   assign rsp_checksum = out_sum_ff;

   always_comb begin
      if (first_ff) begin
         cur_next  = 16'(in_data_ff) + 16'(ttrc_pkg::FIRST_OFFSET);
         prev_next = ttrc_pkg::TERM_ONE;
         idx_next  = 8'd1;
      end else begin
         cur_next  = term;
         prev_next = cur_ff;
         idx_next  = idx_ff + 8'd1;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_last_in  = in_last_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data_byte;
         in_last_in  = req_last_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      first_in = first_ff;
      idx_in   = idx_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      if (advance) begin
         if (in_last_ff) begin
            first_in = 1'b1;
            idx_in   = '0;
            cur_in   = ttrc_pkg::TERM_ONE;
            prev_in  = ttrc_pkg::TERM_ONE;
         end else begin
            first_in = 1'b0;
            idx_in   = idx_next;
            cur_in   = cur_next;
            prev_in  = prev_next;
         end
      end

      out_valid_in = out_valid_ff;
      out_sum_in   = out_sum_ff;
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
         out_sum_in   = cur_next;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         first_ff     <= 1'b1;
         idx_ff       <= '0;
         cur_ff       <= ttrc_pkg::TERM_ONE;
         prev_ff      <= ttrc_pkg::TERM_ONE;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         first_ff     <= first_in;
         idx_ff       <= idx_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      in_last_ff <= in_last_in;
      out_sum_ff <= out_sum_in;
   end

   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      first_ff |-> (idx_ff == '0 && cur_ff == ttrc_pkg::TERM_ONE))
      else $error("index or term not cleared while awaiting first item");

   a_term_range: assert property (@(posedge clock) disable iff (reset)
      cur_ff != ttrc_pkg::TERM_MOD)
      else $error("term out of residue range");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff && out_valid_ff && rsp_stall))
      else $error("stall without a blocked checksum");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (out_valid_ff && first_ff))
      else $error("last item did not produce checksum and re-arm");

endmodule

### hw/rtl/ttrc_term.sv
module ttrc_term (
   input  ttrc_pkg::byte_type data_i,
   input  ttrc_pkg::byte_type idx_i,
   input  ttrc_pkg::term_type cur_i,
   input  ttrc_pkg::term_type prev_i,
   output ttrc_pkg::term_type term_o
);

   ttrc_pkg::byte_type alpha;
   ttrc_pkg::byte_type beta;
   logic [8:0]         sum;
   logic [24:0]        prod_a;
   logic [23:0]        prod_b;
   logic               neg;
   logic [25:0]        biased;
   logic [16:0]        fold1;
   ttrc_pkg::term_type fold2;

   assign alpha = 8'(idx_i * ttrc_pkg::ALPHA_MULT);
   assign beta  = 8'(idx_i * ttrc_pkg::BETA_MULT);
   assign sum   = {1'b0, data_i} + {1'b0, alpha};

   assign prod_a = 25'(sum) * 25'(cur_i);
   assign prod_b = 24'(beta) * 24'(prev_i);

   // adds one when the difference goes negative
   assign neg    = {1'b0, prod_b} > prod_a;
   assign biased = 26'(prod_a) + ttrc_pkg::MOD_BIAS + 26'(neg) - 26'(prod_b);

   // end-around folds, 2^16 is one mod 65535
   assign fold1 = 17'(biased[25:16]) + 17'(biased[15:0]);
   assign fold2 = fold1[15:0] + 16'(fold1[16]);

   assign term_o = (fold2 == ttrc_pkg::TERM_MOD) ? '0 : fold2;

endmodule
